// ----- sv/spe_pkg.sv -----
// Shared types, constants and the microprogram of the swap permutation enumerator.
`timescale 1ns / 1ps

package spe_pkg;

  // Fixed field widths of the channels.
  localparam int COUNT_W = 3;
  localparam int SLOT_W  = 3;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;

  // Input item operation codes.
  localparam logic IN_LOAD = 1'b0;
  localparam logic IN_NEXT = 1'b1;

  // Microprogram counter.
  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  // Datapath actions, one per control word.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_RD_STK,    // read the element at the position held in the stack entry of the level
    DP_RD_LVL,    // keep the first read, read the element at the level's own position
    DP_WR_STK,    // write the second read to the stack entry's position
    DP_WR_LVL,    // write the kept first read to the level's position
    DP_LVL_TOP,   // level to the deepest swapping level
    DP_LVL_DEC,   // one level up
    DP_STK_INC,   // bump the loop index of the level
    DP_DESC,      // reset loop indices below the level
    DP_DESC_ALL,  // reset every loop index and mark the enumeration begun
    DP_RESTART,   // clear the enumeration and apply the pending load or count
    DP_EMIT       // capture the arrangement into the output register
  } dp_op_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_NO_UNW,
    C_LVL_ZERO,
    C_STARTED,
    C_N_ONE,
    C_STK_TOP,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    upc_t   target;
  } uword_t;

  // Datapath flags tested by the sequencer.
  typedef struct packed {
    logic started;
    logic no_unwind;
    logic lvl_zero;
    logic n_one;
    logic stk_top;
    logic out_busy;
  } status_t;

  // Handshake captures seen by the datapath.
  typedef struct packed {
    logic cfg_take;
    logic load_take;
  } capture_t;

  // Microprogram step addresses.
  localparam upc_t U_IDLE      = 5'd0;
  localparam upc_t U_UNW       = 5'd1;
  localparam upc_t U_UNW_RA    = 5'd2;
  localparam upc_t U_UNW_RB    = 5'd3;
  localparam upc_t U_UNW_WA    = 5'd4;
  localparam upc_t U_UNW_WB    = 5'd5;
  localparam upc_t U_UNW_DEC   = 5'd6;
  localparam upc_t U_RESTART   = 5'd7;
  localparam upc_t U_NXT       = 5'd8;
  localparam upc_t U_FIRST     = 5'd9;
  localparam upc_t U_ADV       = 5'd10;
  localparam upc_t U_UNDO_RA   = 5'd11;
  localparam upc_t U_UNDO_RB   = 5'd12;
  localparam upc_t U_UNDO_WA   = 5'd13;
  localparam upc_t U_UNDO_WB   = 5'd14;
  localparam upc_t U_BUMP      = 5'd15;
  localparam upc_t U_DO_RA     = 5'd16;
  localparam upc_t U_DO_RB     = 5'd17;
  localparam upc_t U_DO_WA     = 5'd18;
  localparam upc_t U_DO_WB     = 5'd19;
  localparam upc_t U_DESC      = 5'd20;
  localparam upc_t U_UP        = 5'd21;
  localparam upc_t U_UP_DEC    = 5'd22;
  localparam upc_t U_WRAP      = 5'd23;
  localparam upc_t U_EMIT_WAIT = 5'd24;
  localparam upc_t U_EMIT      = 5'd25;

  // Control store. A swap takes four words through the single read port.
  function automatic uword_t spe_rom(input upc_t addr);
    uword_t w;
    w = '{op: DP_NOP, cond: C_ALWAYS, target: U_IDLE};
    case (addr)
      U_IDLE:      w = '{op: DP_NOP,      cond: C_DISPATCH, target: U_IDLE};
      U_UNW:       w = '{op: DP_LVL_TOP,  cond: C_NO_UNW,   target: U_RESTART};
      U_UNW_RA:    w = '{op: DP_RD_STK,   cond: C_NEXT,     target: U_IDLE};
      U_UNW_RB:    w = '{op: DP_RD_LVL,   cond: C_NEXT,     target: U_IDLE};
      U_UNW_WA:    w = '{op: DP_WR_STK,   cond: C_NEXT,     target: U_IDLE};
      U_UNW_WB:    w = '{op: DP_WR_LVL,   cond: C_LVL_ZERO, target: U_RESTART};
      U_UNW_DEC:   w = '{op: DP_LVL_DEC,  cond: C_ALWAYS,   target: U_UNW_RA};
      U_RESTART:   w = '{op: DP_RESTART,  cond: C_ALWAYS,   target: U_IDLE};
      U_NXT:       w = '{op: DP_NOP,      cond: C_STARTED,  target: U_ADV};
      U_FIRST:     w = '{op: DP_DESC_ALL, cond: C_ALWAYS,   target: U_EMIT_WAIT};
      U_ADV:       w = '{op: DP_LVL_TOP,  cond: C_N_ONE,    target: U_WRAP};
      U_UNDO_RA:   w = '{op: DP_RD_STK,   cond: C_NEXT,     target: U_IDLE};
      U_UNDO_RB:   w = '{op: DP_RD_LVL,   cond: C_NEXT,     target: U_IDLE};
      U_UNDO_WA:   w = '{op: DP_WR_STK,   cond: C_NEXT,     target: U_IDLE};
      U_UNDO_WB:   w = '{op: DP_WR_LVL,   cond: C_NEXT,     target: U_IDLE};
      U_BUMP:      w = '{op: DP_STK_INC,  cond: C_STK_TOP,  target: U_UP};
      U_DO_RA:     w = '{op: DP_RD_STK,   cond: C_NEXT,     target: U_IDLE};
      U_DO_RB:     w = '{op: DP_RD_LVL,   cond: C_NEXT,     target: U_IDLE};
      U_DO_WA:     w = '{op: DP_WR_STK,   cond: C_NEXT,     target: U_IDLE};
      U_DO_WB:     w = '{op: DP_WR_LVL,   cond: C_NEXT,     target: U_IDLE};
      U_DESC:      w = '{op: DP_DESC,     cond: C_ALWAYS,   target: U_EMIT_WAIT};
      U_UP:        w = '{op: DP_NOP,      cond: C_LVL_ZERO, target: U_WRAP};
      U_UP_DEC:    w = '{op: DP_LVL_DEC,  cond: C_ALWAYS,   target: U_UNDO_RA};
      U_WRAP:      w = '{op: DP_DESC_ALL, cond: C_NEXT,     target: U_IDLE};
      U_EMIT_WAIT: w = '{op: DP_NOP,      cond: C_OUT_BUSY, target: U_EMIT_WAIT};
      U_EMIT:      w = '{op: DP_EMIT,     cond: C_ALWAYS,   target: U_IDLE};
      default:     w = '{op: DP_NOP,      cond: C_ALWAYS,   target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/spe_channels.sv -----
// Handshake channel interfaces of the swap permutation enumerator.
`timescale 1ns / 1ps

interface spe_in_if #(
  parameter int ELEM_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [spe_pkg::SLOT_W-1:0]    slot;
  logic signed [ELEM_WIDTH-1:0]  value;

  modport source (output valid, op, slot, value, input ready);
  modport sink   (input valid, op, slot, value, output ready);
endinterface

interface spe_out_if #(
  parameter int MAX_ITEMS  = 6,
  parameter int ELEM_WIDTH = 32
);
  logic                                 valid;
  logic                                 ready;
  logic [MAX_ITEMS-1:0][ELEM_WIDTH-1:0] item;
  logic                                 last;

  modport source (output valid, item, last, input ready);
  modport sink   (input valid, item, last, output ready);
endinterface

interface spe_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [spe_pkg::COUNT_W-1:0] count;

  modport source (output valid, count, input ready);
  modport sink   (input valid, count, output ready);
endinterface

// ----- sv/spe_sequencer.sv -----
// Microprogram sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module spe_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  spe_pkg::status_t  status,
  input  logic              unw_req,
  input  logic              next_req,
  output spe_pkg::dp_op_t   op,
  output logic              idle
);

  spe_pkg::upc_t   upc_r;
  spe_pkg::upc_t   upc_nxt;
  spe_pkg::uword_t uw;
  logic            take;

  assign uw   = spe_pkg::spe_rom(upc_r);
  assign op   = uw.op;
  assign idle = (upc_r == spe_pkg::U_IDLE);

  always_comb begin
    case (uw.cond)
      spe_pkg::C_ALWAYS:   take = 1'b1;
      spe_pkg::C_NO_UNW:   take = status.no_unwind;
      spe_pkg::C_LVL_ZERO: take = status.lvl_zero;
      spe_pkg::C_STARTED:  take = status.started;
      spe_pkg::C_N_ONE:    take = status.n_one;
      spe_pkg::C_STK_TOP:  take = status.stk_top;
      spe_pkg::C_OUT_BUSY: take = status.out_busy;
      default:             take = 1'b0;
    endcase
  end

  always_comb begin
    if (uw.cond == spe_pkg::C_DISPATCH) begin
      if (unw_req) begin
        upc_nxt = spe_pkg::U_UNW;
      end else if (next_req) begin
        upc_nxt = spe_pkg::U_NXT;
      end else begin
        upc_nxt = upc_r;
      end
    end else if (take) begin
      upc_nxt = uw.target;
    end else begin
      upc_nxt = upc_r + spe_pkg::UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= spe_pkg::U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ----- sv/spe_datapath.sv -----
// Datapath: element registers, loop index stack, level pointer and output register.
`timescale 1ns / 1ps

module spe_datapath #(
  parameter int MAX_ITEMS  = 6,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  spe_pkg::dp_op_t                      op,
  input  spe_pkg::capture_t                    cap,
  input  logic [spe_pkg::COUNT_W-1:0]          cfg_count,
  input  logic [spe_pkg::SLOT_W-1:0]           in_slot,
  input  logic [ELEM_WIDTH-1:0]                in_value,
  output spe_pkg::status_t                     status,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [MAX_ITEMS-1:0][ELEM_WIDTH-1:0] out_item,
  output logic                                 out_last
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int IW = $clog2(MAX_ITEMS + 1);

  logic [MAX_ITEMS-1:0][ELEM_WIDTH-1:0] arr_r, arr_nxt;
  logic [MAX_ITEMS-1:0][IW-1:0]         stk_r, stk_nxt;
  logic [AW-1:0]                        lvl_r, lvl_nxt;
  logic                                 started_r, started_nxt;
  logic [spe_pkg::COUNT_W-1:0]          count_r, count_nxt;
  logic [ELEM_WIDTH-1:0]                rd_r, rd_nxt;
  logic [ELEM_WIDTH-1:0]                t_r, t_nxt;
  logic                                 pend_cfg_r, pend_cfg_nxt;
  logic [spe_pkg::COUNT_W-1:0]          pend_count_r, pend_count_nxt;
  logic [spe_pkg::SLOT_W-1:0]           pend_slot_r, pend_slot_nxt;
  logic [ELEM_WIDTH-1:0]                pend_value_r, pend_value_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [MAX_ITEMS-1:0][ELEM_WIDTH-1:0] out_item_r, out_item_nxt;
  logic                                 out_last_r, out_last_nxt;

  logic [IW-1:0]                        n;
  logic [IW-1:0]                        n_m1;
  logic [IW-1:0]                        stk_top;
  logic [AW-1:0]                        raddr;
  logic [ELEM_WIDTH-1:0]                rd_data;
  logic [MAX_ITEMS-1:0][ELEM_WIDTH-1:0] shown;
  logic                                 is_last;

  // Positions in use: a count of zero acts as one, a count beyond the list as the list.
  always_comb begin
    if (count_r == '0) begin
      n = IW'(1);
    end else if (32'(count_r) > 32'(MAX_ITEMS)) begin
      n = IW'(MAX_ITEMS);
    end else begin
      n = IW'(count_r);
    end
  end

  assign n_m1    = n - IW'(1);
  assign stk_top = stk_r[lvl_r];
  assign raddr   = (op == spe_pkg::DP_RD_STK) ? stk_top[AW-1:0] : lvl_r;
  assign rd_data = arr_r[raddr];

  // The final arrangement has every swapping level at the last position.
  always_comb begin
    is_last = 1'b1;
    for (int j = 0; j < MAX_ITEMS - 1; j++) begin
      if (IW'(j) < n_m1 && stk_r[j] != n_m1) begin
        is_last = 1'b0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_ITEMS; j++) begin
      shown[j] = (IW'(j) < n) ? arr_r[j] : '0;
    end
  end

  always_comb begin
    arr_nxt        = arr_r;
    stk_nxt        = stk_r;
    lvl_nxt        = lvl_r;
    started_nxt    = started_r;
    count_nxt      = count_r;
    rd_nxt         = rd_r;
    t_nxt          = t_r;
    pend_cfg_nxt   = pend_cfg_r;
    pend_count_nxt = pend_count_r;
    pend_slot_nxt  = pend_slot_r;
    pend_value_nxt = pend_value_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;

    if (cap.cfg_take) begin
      pend_cfg_nxt   = 1'b1;
      pend_count_nxt = cfg_count;
    end
    if (cap.load_take) begin
      pend_cfg_nxt   = 1'b0;
      pend_slot_nxt  = in_slot;
      pend_value_nxt = in_value;
    end

    case (op)
      spe_pkg::DP_RD_STK: begin
        rd_nxt = rd_data;
      end
      spe_pkg::DP_RD_LVL: begin
        t_nxt  = rd_r;
        rd_nxt = rd_data;
      end
      spe_pkg::DP_WR_STK: begin
        arr_nxt[stk_top[AW-1:0]] = rd_r;
      end
      spe_pkg::DP_WR_LVL: begin
        arr_nxt[lvl_r] = t_r;
      end
      spe_pkg::DP_LVL_TOP: begin
        lvl_nxt = (n > IW'(1)) ? AW'(n - IW'(2)) : '0;
      end
      spe_pkg::DP_LVL_DEC: begin
        lvl_nxt = lvl_r - AW'(1);
      end
      spe_pkg::DP_STK_INC: begin
        stk_nxt[lvl_r] = stk_top + IW'(1);
      end
      spe_pkg::DP_DESC: begin
        for (int j = 0; j < MAX_ITEMS; j++) begin
          if (AW'(j) > lvl_r) begin
            stk_nxt[j] = IW'(j);
          end
        end
      end
      spe_pkg::DP_DESC_ALL: begin
        for (int j = 0; j < MAX_ITEMS; j++) begin
          stk_nxt[j] = IW'(j);
        end
        started_nxt = 1'b1;
      end
      spe_pkg::DP_RESTART: begin
        started_nxt = 1'b0;
        lvl_nxt     = '0;
        if (pend_cfg_r) begin
          count_nxt = pend_count_r;
        end else if (32'(pend_slot_r) < 32'(MAX_ITEMS)) begin
          arr_nxt[AW'(pend_slot_r)] = pend_value_r;
        end
      end
      spe_pkg::DP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = shown;
        out_last_nxt  = is_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arr_r       <= '0;
      stk_r       <= '0;
      lvl_r       <= '0;
      started_r   <= 1'b0;
      count_r     <= spe_pkg::COUNT_RESET;
      pend_cfg_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      arr_r       <= arr_nxt;
      stk_r       <= stk_nxt;
      lvl_r       <= lvl_nxt;
      started_r   <= started_nxt;
      count_r     <= count_nxt;
      pend_cfg_r  <= pend_cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_r         <= rd_nxt;
    t_r          <= t_nxt;
    pend_count_r <= pend_count_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_value_r <= pend_value_nxt;
    out_item_r   <= out_item_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign status.started   = started_r;
  assign status.no_unwind = !started_r || (n < IW'(2));
  assign status.lvl_zero  = (lvl_r == '0);
  assign status.n_one     = (n == IW'(1));
  assign status.stk_top   = (stk_top >= n_m1);
  assign status.out_busy  = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_last  = out_last_r;

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (op == spe_pkg::DP_RESTART) |=> (!started_r && lvl_r == '0))
    else $error("restart left the enumeration running");

  a_swap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (op == spe_pkg::DP_RD_STK || op == spe_pkg::DP_WR_STK) |-> (stk_top < n))
    else $error("swap position beyond the positions in use");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(op) == spe_pkg::DP_EMIT))
    else $error("result appeared without an emit step");

  a_emit_when_started: assert property (@(posedge clk) disable iff (!rst_n)
    (op == spe_pkg::DP_EMIT) |-> started_r)
    else $error("arrangement shown before the enumeration began");

endmodule

// ----- sv/swap_permutation_enumerator.sv -----
// Swap permutation enumerator top level: lists every ordering of a small list, one per item.
//
// Three channels, each a valid/ready pair; a transfer happens on a rising edge of clk with
// both high. cfg_ch writes the number of positions in use. in_ch carries items: a load
// item writes one element and restarts the enumeration without any result, a next item
// yields the following arrangement on out_ch, with last set on the final one; the request
// after the final arrangement starts again from the loaded order.
// A small microprogram steps a plain datapath; each swap of two elements takes four
// steps through the single read port of the element registers, and this sets the rate.
// A first next item shows the loaded order. A later one undoes the swaps from the
// deepest level upward until a level can still move, and makes that level's next swap;
// after the final arrangement it wraps back to the loaded order, as every later request
// does with a single position in use. A load or a count write first undoes the swaps
// of a started enumeration, then applies the new element or count.
// One item is worked on at a time; ready is low on in_ch and cfg_ch until the
// sequencer is back at rest.
// Results sit in an output register, so the next item is taken while a result waits;
// a stalled receiver holds the sequencer only when a further result is ready to go.
// Reset (rst_n low, synchronous) clears the list to zero, sets the count to four and
// leaves the enumeration not begun.
`timescale 1ns / 1ps

module swap_permutation_enumerator #(
  parameter int MAX_ITEMS  = 6,
  parameter int ELEM_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  spe_in_if.sink     in_ch,
  spe_out_if.source  out_ch,
  spe_cfg_if.sink    cfg_ch
);

  spe_pkg::status_t  status;
  spe_pkg::capture_t cap;
  spe_pkg::dp_op_t   op;
  logic              idle;
  logic              in_take;
  logic              next_take;

  // Count writes win over items when both arrive at rest.
  assign cfg_ch.ready = idle;
  assign in_ch.ready  = idle && !cfg_ch.valid;

  assign in_take       = in_ch.valid && in_ch.ready;
  assign cap.cfg_take  = cfg_ch.valid && cfg_ch.ready;
  assign cap.load_take = in_take && (in_ch.op == spe_pkg::IN_LOAD);
  assign next_take     = in_take && (in_ch.op == spe_pkg::IN_NEXT);

  // Both a load and a count write first undo the swaps of a running enumeration.
  spe_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .status   (status),
    .unw_req  (cap.cfg_take || cap.load_take),
    .next_req (next_take),
    .op       (op),
    .idle     (idle)
  );

  spe_datapath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .cap       (cap),
    .cfg_count (cfg_ch.count),
    .in_slot   (in_ch.slot),
    .in_value  (in_ch.value),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.item),
    .out_last  (out_ch.last)
  );

endmodule
